FILE: rtl/core/signed_int_to_decimal_ascii_core_macros.svh
// Assertion helpers shared by the core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SITDA_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("sitda assertion failed");
`define SITDA_NEVER(lbl, ck, rstn, cond) \
	`SITDA_ASSERT(lbl, ck, rstn, !(cond))
`else
`define SITDA_ASSERT(lbl, ck, rstn, prop)
`define SITDA_NEVER(lbl, ck, rstn, cond)
`endif
`endif

FILE: rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and character constants for the integer to decimal text core.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic drop;
		logic push_sign;
		logic push_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic conv_done;
		logic top_zero;
		logic one_left;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii_core.sv
// A minus sign, when the word is negative, follows the conversion; leading zeros are then
//   dropped one at a time before the first digit is emitted.
// Conversion is the one-bit-per-cycle shift-and-add-3 loop over NDIG digit slots (NDIG = 10
//   for 32 bits); a new word is taken only once the last digit has entered the output register.
// Digits leave at one per cycle while the output is not stalled.
// Reset (arst_n low) returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            char_code,
	output logic                  last
);
	import sitda_pkg::*;

	cmd_t    cmd;
	status_t status;

	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sitda_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last      (last)
	);

endmodule

FILE: rtl/core/sitda_dp.sv
// ----------------------------------------------------------------------------
// sitda_dp
// Magnitude, bit-serial BCD conversion, digit shifter and output word register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sitda_pkg::cmd_t         cmd,
	output sitda_pkg::status_t      status,
	input  logic [VALUE_BITS-1:0]   value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              char_code,
	output logic                    last
);
	import sitda_pkg::*;

	// decimal digits of 2^(VALUE_BITS-1), the largest magnitude
	localparam int NDIG = (VALUE_BITS - 1) * 30103 / 100000 + 1;
	localparam int BW   = NDIG * 4;
	localparam int CW   = $clog2(VALUE_BITS + 1);
	localparam int DW   = $clog2(NDIG + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BW-1:0]         bcd_q;
	logic [BW-1:0]         bcd_adj;
	logic [CW-1:0]         cnt_q;
	logic [DW-1:0]         dig_q;
	logic                  neg_q;
	logic                  ovalid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic [3:0]            top_dig;
	logic                  push_any;
	logic                  char_ok;

	assign top_dig = bcd_q[BW-1 -: 4];

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= BCD_ADJ_MIN) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + BCD_ADJ;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// two's complement negate also gives 2^(n-1) for the most negative value
			mag_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BW-2:0], mag_q[VALUE_BITS-1]};
		end else if (cmd.drop) begin
			bcd_q <= bcd_q << 4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dig_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= CW'(VALUE_BITS);
			dig_q <= DW'(NDIG);
			neg_q <= value[VALUE_BITS-1];
		end else begin
			if (cmd.step) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.drop) begin
				dig_q <= dig_q - DW'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.push_sign || cmd.push_digit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.push_digit) begin
			char_q <= CH_ZERO + {4'd0, top_dig};
			last_q <= (dig_q == DW'(1));
		end
	end

	assign status.neg       = neg_q;
	assign status.conv_done = (cnt_q == CW'(1));
	assign status.top_zero  = (top_dig == 4'd0);
	assign status.one_left  = (dig_q == DW'(1));
	assign status.out_free  = !ovalid_q || !out_stall;

	assign out_valid = ovalid_q;
	assign char_code = char_q;
	assign last      = last_q;

	assign push_any = cmd.push_sign || cmd.push_digit;
	assign char_ok  = (char_q == CH_MINUS) || (char_q >= CH_ZERO && char_q <= CH_NINE);

	`SITDA_NEVER(a_no_push_when_held, clk, arst_n, ovalid_q && out_stall && push_any)
	`SITDA_ASSERT(a_minus_not_last, clk, arst_n, (ovalid_q && char_q == CH_MINUS) |-> !last_q)
	`SITDA_ASSERT(a_char_legal, clk, arst_n, ovalid_q |-> char_ok)

endmodule

FILE: rtl/core/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: accept, convert, sign, leading-zero skip and digit emission.
// ----------------------------------------------------------------------------
module sitda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sitda_pkg::status_t  status,
	output sitda_pkg::cmd_t     cmd
);
	import sitda_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (status.conv_done) state_d = status.neg ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				if (status.out_free) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!status.top_zero || status.one_left) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.one_left) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CONV: cmd.step = 1'b1;
			ST_SIGN: cmd.push_sign = status.out_free;
			ST_SKIP: cmd.drop = status.top_zero && !status.one_left;
			ST_EMIT: begin
				cmd.push_digit = status.out_free;
				cmd.drop       = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for signed_int_to_decimal_ascii_core. Words are queued
// by an initial block and fed by a clocked driver. Every accepted word is
// converted to its expected decimal text. A clocked monitor compares each
// character and its last flag in order. Both sides idle at random in two of
// the three phases.
// ----------------------------------------------------------------------------
module tb_top;

	import sitda_pkg::*;

	localparam int VW          = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 2 * VW + 32;
	localparam int RAND_EACH   = 160;
	localparam int PRINT_MAX   = 40;

	typedef enum logic [1:0] {
		PH_RX_HEAVY,	// sender idles a little, receiver stalls a lot
		PH_TX_HEAVY,	// the other way round
		PH_FLOW		// no idling on either side
	} phase_t;

	typedef struct {
		logic [VW-1:0] v;
		phase_t        phase;
		logic          hold;	// wait for all text to drain before offering
	} number_word_t;

	typedef struct {
		logic [7:0]    ch;
		logic          last;
		logic [VW-1:0] src;
	} char_word_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [VW-1:0] value = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [7:0]    char_code;
	logic          last;

	number_word_t numbers_pending[$];
	char_word_t   text_due[$];
	phase_t       cur_phase = PH_RX_HEAVY;
	int           n_mismatch = 0;
	int           n_cycles = 0;

	signed_int_to_decimal_ascii_core #(
		.VALUE_BITS(VW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int idle_pct(input phase_t ph, input logic rx_side);
		case (ph)
			PH_RX_HEAVY: return rx_side ? 78 : 19;
			PH_TX_HEAVY: return rx_side ? 19 : 78;
			default:     return 0;
		endcase
	endfunction

	// Decimal text of one word, appended to the queue of due characters.
	function automatic void predict_text(input logic [VW-1:0] v);
		logic       neg;
		logic [VW:0] mag;
		logic [3:0] dg[$];
		char_word_t c;
		neg = v[VW-1];
		// one bit wider so the most negative value has a magnitude
		mag = neg ? ({VW+1{1'b0}} - {v[VW-1], v}) : {1'b0, v};
		do begin
			dg.push_back(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		c.src = v;
		if (neg) begin
			c.ch   = CH_MINUS;
			c.last = 1'b0;
			text_due.push_back(c);
		end
		for (int i = dg.size() - 1; i >= 0; i--) begin
			c.ch   = CH_ZERO + {4'd0, dg[i]};
			c.last = (i == 0);
			text_due.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] src,
			input int got, input int want);
		if (n_mismatch < PRINT_MAX)
			$display("mismatch at %0t: %s for %0d: got %0d, expected %0d",
				$realtime, what, $signed(src), got, want);
		n_mismatch++;
	endtask

	function automatic logic [VW-1:0] pick_value();
		logic [VW-1:0] r;
		logic [VW-1:0] t;
		logic [63:0]   p;
		int            k;
		p = 64'd1;
		case ($urandom_range(0, 9))
			0, 1, 2: r = $urandom();
			3, 4, 5: begin
				t = $urandom();
				r = $signed(t) >>> $urandom_range(0, VW - 1);
			end
			6, 7, 8: begin
				// around a power of ten, either sign
				k = $urandom_range(1, 9);
				for (int i = 0; i < k; i++)
					p = p * 10;
				r = p[VW-1:0] + VW'($urandom_range(0, 2)) - VW'(1);
				if ($urandom_range(0, 1))
					r = -r;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: r = {1'b1, {VW-1{1'b0}}};
					1: r = {1'b0, {VW-1{1'b1}}};
					2: r = '0;
					default: r = '1;
				endcase
			end
		endcase
		return r;
	endfunction

	// Driver: offers the next queued word once the current one is taken.
	always @(posedge clk or negedge arst_n) begin : feeder
		logic         free;
		logic         go;
		number_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			free = !in_valid || !in_stall;
			if (in_valid && !in_stall)
				predict_text(value);
			if (free) begin
				go = 1'b0;
				if (numbers_pending.size() != 0) begin
					nxt = numbers_pending[0];
					go = !(nxt.hold && text_due.size() != 0) &&
						($urandom_range(0, 99) >= idle_pct(nxt.phase, 1'b0));
				end
				if (go) begin
					void'(numbers_pending.pop_front());
					value     <= nxt.v;
					cur_phase <= nxt.phase;
				end
				in_valid <= go;
			end
		end
	end

	// Monitor: checks each character taken against the oldest one due.
	always @(posedge clk or negedge arst_n) begin : sink
		char_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (text_due.size() == 0) begin
					report_mismatch("character with nothing due", '0, char_code, 0);
				end else begin
					want = text_due.pop_front();
					if (char_code !== want.ch)
						report_mismatch("char_code", want.src, char_code, want.ch);
					if (last !== want.last)
						report_mismatch("last", want.src, last, want.last);
				end
			end
			out_stall <= ($urandom_range(0, 99) < idle_pct(cur_phase, 1'b1));
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		logic [VW-1:0] directed[$];
		number_word_t  w;
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
			32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd123456789,
			-32'sd5, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967286, 32'd7};
		foreach (directed[i]) begin
			w.v     = directed[i];
			w.phase = PH_RX_HEAVY;
			w.hold  = (i == 10);
			numbers_pending.push_back(w);
		end
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < RAND_EACH; i++) begin
				w.v     = pick_value();
				w.phase = phase_t'(ph);
				w.hold  = (i == 0) || ($urandom_range(0, 99) == 0);
				numbers_pending.push_back(w);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (text_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (n_mismatch == 0 && text_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
